// ----- hw/rtl/rgbled_pkg.sv -----
package rgbled_pkg;

  localparam int unsigned CHAN_IN_W   = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned SHORT_W     = 8;

  // Register map
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP       = 3'd4;

  localparam logic [SHORT_W-1:0] ZERO_HIGH_RST = 8'd7;
  localparam logic [SHORT_W-1:0] ZERO_LOW_RST  = 8'd16;
  localparam logic [SHORT_W-1:0] ONE_HIGH_RST  = 8'd14;
  localparam logic [SHORT_W-1:0] ONE_LOW_RST   = 8'd12;
  localparam logic [TICK_W-1:0]  GAP_RST       = 16'd1000;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  // Phase lengths, already forced to at least one tick
  typedef struct packed {
    logic [SHORT_W-1:0] zero_high;
    logic [SHORT_W-1:0] zero_low;
    logic [SHORT_W-1:0] one_high;
    logic [SHORT_W-1:0] one_low;
    logic [TICK_W-1:0]  gap;
  } cfg_t;

endpackage

// ----- hw/rtl/rgbled_if.sv -----
interface rgbled_item_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [rgbled_pkg::CHAN_IN_W-1:0]   red;
  logic [rgbled_pkg::CHAN_IN_W-1:0]   green;
  logic [rgbled_pkg::CHAN_IN_W-1:0]   blue;

  modport source (output valid, kind, red, green, blue, input ready);
  modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface rgbled_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic dropped;

  modport source (output valid, line_level, busy_res, dropped, input ready);
  modport sink   (input valid, line_level, busy_res, dropped, output ready);
endinterface

// ----- hw/rtl/rgbled_cfg.sv -----
module rgbled_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rgbled_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgbled_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rgbled_pkg::cfg_t                    cfg
);

  logic [rgbled_pkg::SHORT_W-1:0] zero_high;
  logic [rgbled_pkg::SHORT_W-1:0] zero_low;
  logic [rgbled_pkg::SHORT_W-1:0] one_high;
  logic [rgbled_pkg::SHORT_W-1:0] one_low;
  logic [rgbled_pkg::TICK_W-1:0]  gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high <= rgbled_pkg::ZERO_HIGH_RST;
      zero_low  <= rgbled_pkg::ZERO_LOW_RST;
      one_high  <= rgbled_pkg::ONE_HIGH_RST;
      one_low   <= rgbled_pkg::ONE_LOW_RST;
      gap       <= rgbled_pkg::GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbled_pkg::REG_ZERO_HIGH: zero_high <= cfg_data[rgbled_pkg::SHORT_W-1:0];
        rgbled_pkg::REG_ZERO_LOW:  zero_low  <= cfg_data[rgbled_pkg::SHORT_W-1:0];
        rgbled_pkg::REG_ONE_HIGH:  one_high  <= cfg_data[rgbled_pkg::SHORT_W-1:0];
        rgbled_pkg::REG_ONE_LOW:   one_low   <= cfg_data[rgbled_pkg::SHORT_W-1:0];
        rgbled_pkg::REG_GAP:       gap       <= cfg_data[rgbled_pkg::TICK_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Every phase lasts at least one tick: a zero count acts as one
  always_comb begin
    cfg.zero_high = (zero_high == '0) ? 8'd1 : zero_high;
    cfg.zero_low  = (zero_low  == '0) ? 8'd1 : zero_low;
    cfg.one_high  = (one_high  == '0) ? 8'd1 : one_high;
    cfg.one_low   = (one_low   == '0) ? 8'd1 : one_low;
    cfg.gap       = (gap       == '0) ? 16'd1 : gap;
  end

endmodule

// ----- hw/rtl/rgb_led_serial_encoder_core.sv -----
// Single-wire RGB LED encoder. Each request on items is either a pixel load
// (kind 0) or one time tick (kind 1). A pixel is taken only while the block is
// idle and is then sent as one word of green, red, blue, MSB first; a pixel
// that arrives while busy is dropped and flagged. Each tick request returns
// the data line level for that tick and advances the waveform by one tick.
// Exactly one result is returned per request, from a result register, in the
// cycle after the request is taken. One request is taken every cycle: items
// is ready whenever the result register is empty or being read in the same
// cycle, so throughput is set only by the consumer of results. Phase lengths
// come from the configuration registers (a count of zero acts as one); a
// write takes effect from the next phase that starts.
module rgb_led_serial_encoder_core #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  rgbled_item_if.sink                         items,
  rgbled_res_if.source                        results,
  input  logic                                cfg_we,
  input  logic [rgbled_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgbled_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned WordBits = 3 * CHANNEL_BITS;
  localparam int unsigned CountW   = $clog2(WordBits + 1);

  rgbled_pkg::cfg_t cfg;

  rgbled_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Channel fields trimmed or zero-extended to CHANNEL_BITS
  logic [CHANNEL_BITS-1:0] red_ch;
  logic [CHANNEL_BITS-1:0] green_ch;
  logic [CHANNEL_BITS-1:0] blue_ch;

  if (CHANNEL_BITS <= rgbled_pkg::CHAN_IN_W) begin : g_trim
    assign red_ch   = items.red[CHANNEL_BITS-1:0];
    assign green_ch = items.green[CHANNEL_BITS-1:0];
    assign blue_ch  = items.blue[CHANNEL_BITS-1:0];
  end else begin : g_extend
    assign red_ch   = {{(CHANNEL_BITS - rgbled_pkg::CHAN_IN_W){1'b0}}, items.red};
    assign green_ch = {{(CHANNEL_BITS - rgbled_pkg::CHAN_IN_W){1'b0}}, items.green};
    assign blue_ch  = {{(CHANNEL_BITS - rgbled_pkg::CHAN_IN_W){1'b0}}, items.blue};
  end

  rgbled_pkg::phase_t           phase;
  rgbled_pkg::phase_t           phase_next;
  logic [WordBits-1:0]          pixel_shift;
  logic [WordBits-1:0]          pixel_shift_next;
  logic [CountW-1:0]            bits_left;
  logic [CountW-1:0]            bits_left_next;
  logic [rgbled_pkg::TICK_W-1:0] ticks_left;
  logic [rgbled_pkg::TICK_W-1:0] ticks_left_next;

  logic                          res_valid;
  logic                          line_level;
  logic                          busy_res;
  logic                          dropped;
  logic                          level_next;
  logic                          busy_next;
  logic                          drop_next;

  logic                          accept;
  logic [WordBits-1:0]           load_word;
  logic [WordBits-1:0]           shifted;
  logic [rgbled_pkg::TICK_W-1:0] ticks_dec;
  logic [CountW-1:0]             bits_dec;

  assign items.ready = !res_valid || results.ready;
  assign accept      = items.valid && items.ready;

  assign load_word = {green_ch, red_ch, blue_ch};
  assign shifted   = {pixel_shift[WordBits-2:0], 1'b0};
  assign ticks_dec = (ticks_left != '0) ? ticks_left - 1'b1 : '0;
  assign bits_dec  = (bits_left != '0) ? bits_left - 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rgbled_pkg::PH_IDLE;
      pixel_shift <= '0;
      bits_left   <= '0;
      ticks_left  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      pixel_shift <= pixel_shift_next;
      bits_left   <= bits_left_next;
      ticks_left  <= ticks_left_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    pixel_shift_next = pixel_shift;
    bits_left_next   = bits_left;
    ticks_left_next  = ticks_left;
    level_next       = 1'b0;
    busy_next        = 1'b0;
    drop_next        = 1'b0;
    if (items.kind == rgbled_pkg::KIND_PIXEL) begin
      busy_next = 1'b1;
      if (phase != rgbled_pkg::PH_IDLE) begin
        drop_next = 1'b1;
      end else begin
        pixel_shift_next = load_word;
        bits_left_next   = CountW'(WordBits);
        phase_next       = rgbled_pkg::PH_HIGH;
        ticks_left_next  = {8'd0, load_word[WordBits-1] ? cfg.one_high : cfg.zero_high};
      end
    end else if (phase != rgbled_pkg::PH_IDLE) begin
      busy_next       = 1'b1;
      level_next      = (phase == rgbled_pkg::PH_HIGH);
      ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        unique case (phase)
          rgbled_pkg::PH_HIGH: begin
            phase_next      = rgbled_pkg::PH_LOW;
            ticks_left_next = {8'd0, pixel_shift[WordBits-1] ? cfg.one_low : cfg.zero_low};
          end
          rgbled_pkg::PH_LOW: begin
            pixel_shift_next = shifted;
            bits_left_next   = bits_dec;
            if (bits_dec != '0) begin
              phase_next      = rgbled_pkg::PH_HIGH;
              ticks_left_next = {8'd0, shifted[WordBits-1] ? cfg.one_high : cfg.zero_high};
            end else begin
              phase_next      = rgbled_pkg::PH_GAP;
              ticks_left_next = cfg.gap;
            end
          end
          rgbled_pkg::PH_GAP, rgbled_pkg::PH_IDLE: begin
            phase_next      = rgbled_pkg::PH_IDLE;
            ticks_left_next = '0;
          end
        endcase
      end
    end
  end

  // Result register: hold until taken, refill on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level <= level_next;
      busy_res   <= busy_next;
      dropped    <= drop_next;
    end
  end

  assign results.valid      = res_valid;
  assign results.line_level = line_level;
  assign results.busy_res   = busy_res;
  assign results.dropped    = dropped;

endmodule

// ----- hw/rtl/rgbled_checker.sv -----
module rgbled_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic res_valid,
  input logic res_ready,
  input logic line_level,
  input logic busy_res,
  input logic dropped
);

  // Every accepted request shows its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> res_valid)
    else $error("accepted request produced no result");

  // A stalled result holds its payload
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(line_level) && $stable(busy_res)
      && $stable(dropped))
    else $error("stalled result changed");

  // A dropped pixel always reports busy
  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && dropped |-> busy_res)
    else $error("dropped pixel without busy");

  // The line is only driven high while a pixel is in progress
  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && line_level |-> busy_res && !dropped)
    else $error("line high while idle or on a dropped pixel");

endmodule

bind rgb_led_serial_encoder_core rgbled_checker u_rgbled_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .line_level (results.line_level),
  .busy_res   (results.busy_res),
  .dropped    (results.dropped)
);

// ----- dv/tb_rgb_led_serial_encoder_core.sv -----
`timescale 1ns / 1ps

module tb_rgb_led_serial_encoder_core;

  localparam int unsigned CHAN_IN_W   = rgbled_pkg::CHAN_IN_W;
  localparam int unsigned CFG_INDEX_W = rgbled_pkg::CFG_INDEX_W;
  localparam int unsigned CFG_DATA_W  = rgbled_pkg::CFG_DATA_W;
  localparam int unsigned TICK_W      = rgbled_pkg::TICK_W;
  localparam int unsigned SHORT_W     = rgbled_pkg::SHORT_W;

  localparam int unsigned WORD_W          = 3 * CHAN_IN_W;
  localparam int unsigned NUM_PHASES      = 3;
  localparam int unsigned MAX_PHASE       = 1;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned MAX_HIGH_TICKS  = 255;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned END_CYCLES      = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;

  // Index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic dropped;
  } led_res_t;

  localparam led_res_t RES_IDLE    = 3'b000;
  localparam led_res_t RES_TAKEN   = 3'b010;
  localparam led_res_t RES_DROPPED = 3'b011;
  localparam led_res_t RES_HIGH    = 3'b110;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_DRAIN,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t                op;
    logic                   kind;
    logic [CHAN_IN_W-1:0]   red;
    logic [CHAN_IN_W-1:0]   green;
    logic [CHAN_IN_W-1:0]   blue;
    logic                   typed;
    led_res_t               want;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rgbled_item_if item_ch ();
  rgbled_res_if  res_ch ();

  rgb_led_serial_encoder_core #(
    .CHANNEL_BITS(CHAN_IN_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .items    (item_ch),
    .results  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state and register copy
  logic [SHORT_W-1:0] c_zero_high;
  logic [SHORT_W-1:0] c_zero_low;
  logic [SHORT_W-1:0] c_one_high;
  logic [SHORT_W-1:0] c_one_low;
  logic [TICK_W-1:0]  c_gap;
  logic [WORD_W-1:0]  m_word;
  logic [4:0]         m_bits;
  rgbled_pkg::phase_t m_phase;
  logic [TICK_W-1:0]  m_left;

  led_res_t    pending_line_q[$];
  stim_row_t   stim_rows[$];
  int unsigned fails;
  int unsigned items_done;
  bit          quiet_tail;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [TICK_W-1:0] bit_time(input logic high_part);
    logic [SHORT_W-1:0] n;
    if (m_word[WORD_W-1]) begin
      n = high_part ? c_one_high : c_one_low;
    end else begin
      n = high_part ? c_zero_high : c_zero_low;
    end
    return (n == '0) ? TICK_W'(1) : TICK_W'(n);
  endfunction

  function automatic led_res_t predict_line(input logic kind, input logic [CHAN_IN_W-1:0] r,
                                            input logic [CHAN_IN_W-1:0] g,
                                            input logic [CHAN_IN_W-1:0] b);
    led_res_t res;
    res = RES_IDLE;
    if (kind == rgbled_pkg::KIND_PIXEL) begin
      res.busy = 1'b1;
      if (m_phase != rgbled_pkg::PH_IDLE) begin
        res.dropped = 1'b1;
      end else begin
        m_word  = {g, r, b};
        m_bits  = 5'(WORD_W);
        m_phase = rgbled_pkg::PH_HIGH;
        m_left  = bit_time(1'b1);
      end
    end else if (m_phase != rgbled_pkg::PH_IDLE) begin
      res.busy       = 1'b1;
      res.line_level = (m_phase == rgbled_pkg::PH_HIGH);
      if (m_left != '0) m_left = m_left - 1'b1;
      if (m_left == '0) begin
        case (m_phase)
          rgbled_pkg::PH_HIGH: begin
            m_phase = rgbled_pkg::PH_LOW;
            m_left  = bit_time(1'b0);
          end
          rgbled_pkg::PH_LOW: begin
            m_word = m_word << 1;
            if (m_bits != '0) m_bits = m_bits - 1'b1;
            if (m_bits != '0) begin
              m_phase = rgbled_pkg::PH_HIGH;
              m_left  = bit_time(1'b1);
            end else begin
              m_phase = rgbled_pkg::PH_GAP;
              m_left  = (c_gap == '0) ? TICK_W'(1) : c_gap;
            end
          end
          default: begin
            m_phase = rgbled_pkg::PH_IDLE;
            m_left  = '0;
          end
        endcase
      end
    end
    return res;
  endfunction

  function automatic logic [CHAN_IN_W-1:0] pick_chan();
    logic [CHAN_IN_W-1:0] v;
    v = CHAN_IN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic stim_row_t item_row(input logic kind, input logic [CHAN_IN_W-1:0] r,
                                         input logic [CHAN_IN_W-1:0] g,
                                         input logic [CHAN_IN_W-1:0] b,
                                         input logic typed, input led_res_t want);
    stim_row_t row;
    row       = '0;
    row.op    = ROW_ITEM;
    row.kind  = kind;
    row.red   = r;
    row.green = g;
    row.blue  = b;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row      = '0;
    row.op   = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t drain_row();
    stim_row_t row;
    row    = '0;
    row.op = ROW_DRAIN;
    return row;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      fails++;
    end
  endfunction

  // Hold the request until taken, then advance the predictor
  task automatic send_item(input logic kind, input logic [CHAN_IN_W-1:0] r,
                           input logic [CHAN_IN_W-1:0] g, input logic [CHAN_IN_W-1:0] b,
                           input logic typed, input led_res_t want);
    led_res_t guess;
    item_ch.valid <= 1'b1;
    item_ch.kind  <= kind;
    item_ch.red   <= r;
    item_ch.green <= g;
    item_ch.blue  <= b;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    guess = predict_line(kind, r, g, b);
    pending_line_q.push_back(typed ? want : guess);
    items_done++;
  endtask

  task automatic send_tick();
    send_item(rgbled_pkg::KIND_TICK, CHAN_IN_W'($urandom_range(0, 255)),
              CHAN_IN_W'($urandom_range(0, 255)), CHAN_IN_W'($urandom_range(0, 255)),
              1'b0, RES_IDLE);
  endtask

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_pixel();
    while (m_phase != rgbled_pkg::PH_IDLE) begin
      sender_gap();
      send_tick();
    end
  endtask

  // Drop valid and wait for every result before touching the registers
  task automatic settle_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rgbled_pkg::REG_ZERO_HIGH: c_zero_high = data[SHORT_W-1:0];
      rgbled_pkg::REG_ZERO_LOW:  c_zero_low  = data[SHORT_W-1:0];
      rgbled_pkg::REG_ONE_HIGH:  c_one_high  = data[SHORT_W-1:0];
      rgbled_pkg::REG_ONE_LOW:   c_one_low   = data[SHORT_W-1:0];
      rgbled_pkg::REG_GAP:       c_gap       = data[TICK_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: stall in short bursts until the quiet tail
  initial begin
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet_tail) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    led_res_t want;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_line_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %0b%0b%0b", $time,
                 res_ch.line_level, res_ch.busy_res, res_ch.dropped);
        fails++;
      end else begin
        want = pending_line_q.pop_front();
        check_field("line_level", want.line_level, res_ch.line_level);
        check_field("busy_res", want.busy, res_ch.busy_res);
        check_field("dropped", want.dropped, res_ch.dropped);
      end
    end
  end

  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || cfg_we === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("** rgb_led_serial_encoder_core: FAILED **");
    $finish;
  end

  initial begin
    logic [SHORT_W-1:0] zh, zl, oh, ol;
    logic [TICK_W-1:0]  gap;
    logic [SHORT_W-1:0] junk;
    int unsigned        phase_start;
    int unsigned        mode;

    fails      = 0;
    items_done = 0;
    quiet_tail = 1'b0;

    item_ch.valid <= 1'b0;
    item_ch.kind  <= rgbled_pkg::KIND_PIXEL;
    item_ch.red   <= '0;
    item_ch.green <= '0;
    item_ch.blue  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= rgbled_pkg::REG_ZERO_HIGH;
    cfg_data      <= '0;
    rst           <= 1'b1;

    c_zero_high = rgbled_pkg::ZERO_HIGH_RST;
    c_zero_low  = rgbled_pkg::ZERO_LOW_RST;
    c_one_high  = rgbled_pkg::ONE_HIGH_RST;
    c_one_low   = rgbled_pkg::ONE_LOW_RST;
    c_gap       = rgbled_pkg::GAP_RST;
    m_word      = '0;
    m_bits      = '0;
    m_phase     = rgbled_pkg::PH_IDLE;
    m_left      = '0;

    // Reset timing first, then the shortest and zero counts; the first pixel
    // finishes on the shortest counts
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b1, RES_IDLE));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1, RES_TAKEN));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                 RES_DROPPED));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b1, RES_HIGH));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b0, RES_IDLE));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ZERO_HIGH, 16'h0001));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ZERO_LOW, 16'h0001));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ONE_HIGH, 16'h0001));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ONE_LOW, 16'h0001));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_GAP, 16'h0001));
    stim_rows.push_back(cfg_row(REG_SPARE, 16'hFFFF));
    stim_rows.push_back(drain_row());
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, RES_IDLE));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b1, RES_TAKEN));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b1, RES_HIGH));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0, RES_IDLE));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1,
                                 RES_DROPPED));
    stim_rows.push_back(drain_row());
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ZERO_HIGH, 16'h0000));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ZERO_LOW, 16'h0000));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ONE_HIGH, 16'hFF00));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_ONE_LOW, 16'h0000));
    stim_rows.push_back(cfg_row(rgbled_pkg::REG_GAP, 16'h0000));
    stim_rows.push_back(item_row(rgbled_pkg::KIND_PIXEL, 8'hA5, 8'h5A, 8'h3C, 1'b0, RES_IDLE));
    stim_rows.push_back(drain_row());
    stim_rows.push_back(item_row(rgbled_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b1, RES_IDLE));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      case (stim_rows[i].op)
        ROW_ITEM: begin
          sender_gap();
          send_item(stim_rows[i].kind, stim_rows[i].red, stim_rows[i].green,
                    stim_rows[i].blue, stim_rows[i].typed, stim_rows[i].want);
        end
        ROW_DRAIN: drain_pixel();
        default: begin
          settle_idle();
          write_reg(stim_rows[i].idx, stim_rows[i].data);
        end
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      quiet_tail = (ph == NUM_PHASES - 1);
      if (ph == MAX_PHASE) begin
        zh  = '1;
        zl  = SHORT_W'($urandom_range(0, 3));
        oh  = '1;
        ol  = SHORT_W'($urandom_range(0, 3));
        gap = '1;
      end else begin
        zh  = SHORT_W'($urandom_range(0, 3));
        zl  = SHORT_W'($urandom_range(0, 3));
        oh  = SHORT_W'($urandom_range(0, 3));
        ol  = SHORT_W'($urandom_range(0, 3));
        gap = TICK_W'($urandom_range(0, 8));
      end
      junk = SHORT_W'($urandom_range(0, 255));
      write_reg(rgbled_pkg::REG_ZERO_HIGH, {junk, zh});
      junk = SHORT_W'($urandom_range(0, 255));
      write_reg(rgbled_pkg::REG_ZERO_LOW, {junk, zl});
      junk = SHORT_W'($urandom_range(0, 255));
      write_reg(rgbled_pkg::REG_ONE_HIGH, {junk, oh});
      junk = SHORT_W'($urandom_range(0, 255));
      write_reg(rgbled_pkg::REG_ONE_LOW, {junk, ol});
      write_reg(rgbled_pkg::REG_GAP, gap);

      if (ph == MAX_PHASE) begin
        // Run the longest high half of the first bit, then leave the rest of the
        // pixel to the short counts of the next phase
        send_item(rgbled_pkg::KIND_PIXEL, pick_chan(), pick_chan(), pick_chan(), 1'b0,
                  RES_IDLE);
        repeat (MAX_HIGH_TICKS) send_tick();
      end else begin
        phase_start = items_done;
        while (items_done - phase_start < ITEMS_PER_PHASE) begin
          mode = $urandom_range(0, 9);
          sender_gap();
          if (mode < 7) begin
            send_item(rgbled_pkg::KIND_PIXEL, pick_chan(), pick_chan(), pick_chan(), 1'b0,
                      RES_IDLE);
            while (m_phase != rgbled_pkg::PH_IDLE) begin
              sender_gap();
              if (!quiet_tail && $urandom_range(0, 49) == 0) begin
                // Hold off until the result side has caught up
                item_ch.valid <= 1'b0;
                do @(posedge clk); while (pending_line_q.size() != 0);
              end
              if ($urandom_range(0, 39) == 0) begin
                send_item(rgbled_pkg::KIND_PIXEL, pick_chan(), pick_chan(), pick_chan(),
                          1'b0, RES_IDLE);
              end else begin
                send_tick();
              end
            end
          end else if (mode == 7) begin
            send_tick();
          end else begin
            // Send another pixel while this one is still in progress, so that it is dropped
            send_item(rgbled_pkg::KIND_PIXEL, pick_chan(), pick_chan(), pick_chan(), 1'b0,
                      RES_IDLE);
            repeat ($urandom_range(1, 20)) begin
              sender_gap();
              send_tick();
            end
            sender_gap();
            send_item(rgbled_pkg::KIND_PIXEL, pick_chan(), pick_chan(), pick_chan(), 1'b0,
                      RES_IDLE);
          end
        end
        drain_pixel();
      end
    end

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_line_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("** rgb_led_serial_encoder_core: PASSED **");
    end else begin
      $display("** rgb_led_serial_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
